[sv/assert_macros.svh]
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset
`define CPP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define CPP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/cpp_pkg.sv]
package cpp_pkg;

  localparam int SCR_W     = 32;
  localparam int TRIG_W    = 16;
  localparam int ANG_IDX_W = 7;
  localparam int ROUND_SH  = 14;
  localparam int ROUND_HALF = 8192;
  localparam int FOCAL_Q8  = 10 * 256;
  localparam int CENTRE_X_Q8 = (1920 / 2) * 256;
  localparam int CENTRE_Y_Q8 = (1080 / 2) * 256;
  localparam int CAM_Z_RESET = 25600;

  localparam logic signed [SCR_W-1:0] SCR_MAX = 32'sh7fffffff;
  localparam logic signed [SCR_W-1:0] SCR_MIN = 32'sh80000000;

  typedef enum logic [2:0] {
    REG_CAMERA_X,
    REG_CAMERA_Y,
    REG_CAMERA_Z,
    REG_ANGLE_X,
    REG_ANGLE_Y,
    REG_ANGLE_Z
  } cpp_reg_t;

  // sideband that travels alongside the divider
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic vis;
  } cpp_tag_t;

  localparam logic signed [TRIG_W-1:0] QSINE [33] = '{
    16'sd0,     16'sd804,   16'sd1606,  16'sd2404,  16'sd3196,  16'sd3981,
    16'sd4756,  16'sd5520,  16'sd6270,  16'sd7005,  16'sd7723,  16'sd8423,
    16'sd9102,  16'sd9760,  16'sd10394, 16'sd11003, 16'sd11585, 16'sd12140,
    16'sd12665, 16'sd13160, 16'sd13623, 16'sd14053, 16'sd14449, 16'sd14811,
    16'sd15137, 16'sd15426, 16'sd15679, 16'sd15893, 16'sd16069, 16'sd16207,
    16'sd16305, 16'sd16364, 16'sd16384
  };

  // Q1.14 sine of a 128-step turn index
  function automatic logic signed [TRIG_W-1:0] cpp_sin(input logic [ANG_IDX_W-1:0] idx);
    logic [1:0]               quad;
    logic [4:0]               frac;
    logic [5:0]               ti;
    logic signed [TRIG_W-1:0] mag;
    quad = idx[6:5];
    frac = idx[4:0];
    ti   = quad[0] ? (6'd32 - {1'b0, frac}) : {1'b0, frac};
    mag  = QSINE[ti];
    return quad[1] ? -mag : mag;
  endfunction

endpackage

[sv/cpp_if.sv]
interface cpp_pt_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface cpp_scr_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic               visible;

  modport source (output valid, screen_x, screen_y, visible, input ready);
  modport sink   (input valid, screen_x, screen_y, visible, output ready);
endinterface

[sv/cpp_div.sv]
// Pipelined restoring divider: one quotient bit per stage, two numerators
// sharing one divisor.
module cpp_div
  import cpp_pkg::*;
#(
  parameter int NB = 40,
  parameter int DB = 29
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NB-1:0] in_nx,
  input  logic [NB-1:0] in_ny,
  input  logic [DB-1:0] in_den,
  input  cpp_tag_t      in_tag,
  output logic          out_vld,
  output logic [NB-1:0] out_qx,
  output logic [NB-1:0] out_qy,
  output cpp_tag_t      out_tag
);

  logic [NB-1:0] vld_r;
  logic [NB-1:0] nx_r  [NB];
  logic [NB-1:0] ny_r  [NB];
  logic [NB-1:0] qx_r  [NB];
  logic [NB-1:0] qy_r  [NB];
  logic [DB-1:0] rx_r  [NB];
  logic [DB-1:0] ry_r  [NB];
  logic [DB-1:0] den_r [NB];
  cpp_tag_t      tag_r [NB];

  for (genvar s = 0; s < NB; s++) begin : g_st
    logic          v_in;
    logic [NB-1:0] nx_in, ny_in, qx_in, qy_in;
    logic [DB-1:0] rx_in, ry_in, d_in;
    cpp_tag_t      t_in;
    logic [DB:0]   tx, ty, dx_sub, dy_sub;
    logic          gex, gey;
    logic [NB-1:0] qx_nxt, qy_nxt;
    logic [DB-1:0] rx_nxt, ry_nxt;

    if (s == 0) begin : g_first
      assign v_in  = in_vld;
      assign nx_in = in_nx;
      assign ny_in = in_ny;
      assign qx_in = '0;
      assign qy_in = '0;
      assign rx_in = '0;
      assign ry_in = '0;
      assign d_in  = in_den;
      assign t_in  = in_tag;
    end else begin : g_next
      assign v_in  = vld_r[s-1];
      assign nx_in = nx_r[s-1];
      assign ny_in = ny_r[s-1];
      assign qx_in = qx_r[s-1];
      assign qy_in = qy_r[s-1];
      assign rx_in = rx_r[s-1];
      assign ry_in = ry_r[s-1];
      assign d_in  = den_r[s-1];
      assign t_in  = tag_r[s-1];
    end

    always_comb begin
      tx     = {rx_in, nx_in[NB-1-s]};
      ty     = {ry_in, ny_in[NB-1-s]};
      gex    = tx >= {1'b0, d_in};
      gey    = ty >= {1'b0, d_in};
      dx_sub = tx - {1'b0, d_in};
      dy_sub = ty - {1'b0, d_in};
      rx_nxt = gex ? dx_sub[DB-1:0] : tx[DB-1:0];
      ry_nxt = gey ? dy_sub[DB-1:0] : ty[DB-1:0];
      qx_nxt = qx_in;
      qy_nxt = qy_in;
      qx_nxt[NB-1-s] = gex;
      qy_nxt[NB-1-s] = gey;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nx_r[s]  <= nx_in;
        ny_r[s]  <= ny_in;
        qx_r[s]  <= qx_nxt;
        qy_r[s]  <= qy_nxt;
        rx_r[s]  <= rx_nxt;
        ry_r[s]  <= ry_nxt;
        den_r[s] <= d_in;
        tag_r[s] <= t_in;
      end
    end
  end

  assign out_vld = vld_r[NB-1];
  assign out_qx  = qx_r[NB-1];
  assign out_qy  = qy_r[NB-1];
  assign out_tag = tag_r[NB-1];

endmodule

[sv/camera_point_projection_unit.sv]
// Camera point projection: one world point (Q15.8) per beat in, one screen
// point (Q23.8, saturated) with a visible flag per beat out. The unit takes a
// point every clock unless the result side stalls; the restoring divider in
// the pipeline resolves one quotient bit per stage. A stall on the result
// side halts the whole pipeline. The user must write camera position and
// angles through the cfg_ port only while no points are in flight; the block
// itself does not enforce this. They take effect at once.
module camera_point_projection_unit
  import cpp_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int ANGLE_BITS = 16,
  localparam int CFG_W = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  cpp_pt_if.sink           in_pt,
  cpp_scr_if.source        out_scr,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int RW = COORD_BITS + 5;   // rotated values
  localparam int PW = RW + TRIG_W;      // trig products
  localparam int NW = RW + 12;          // scaled numerator, signed
  localparam int NB = RW + 11;          // numerator magnitude
  localparam int DB = RW;               // depth magnitude
  localparam int SW = NB + 2;           // final sum

  function automatic logic signed [RW-1:0] rnd(input logic signed [PW:0] t);
    logic signed [PW:0] s;
    s = (t + (PW+1)'(ROUND_HALF)) >>> ROUND_SH;
    return s[RW-1:0];
  endfunction

  // configuration
  logic signed [COORD_BITS-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic [ANGLE_BITS-1:0]        ang_x_r, ang_y_r, ang_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= COORD_BITS'(CAM_Z_RESET);
      ang_x_r <= '0;
      ang_y_r <= '0;
      ang_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cpp_reg_t'(cfg_idx))
        REG_CAMERA_X: cam_x_r <= cfg_wdata[COORD_BITS-1:0];
        REG_CAMERA_Y: cam_y_r <= cfg_wdata[COORD_BITS-1:0];
        REG_CAMERA_Z: cam_z_r <= cfg_wdata[COORD_BITS-1:0];
        REG_ANGLE_X:  ang_x_r <= cfg_wdata[ANGLE_BITS-1:0];
        REG_ANGLE_Y:  ang_y_r <= cfg_wdata[ANGLE_BITS-1:0];
        REG_ANGLE_Z:  ang_z_r <= cfg_wdata[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [ANG_IDX_W-1:0] ix, iy, iz;
  logic signed [TRIG_W-1:0] sx, cx, sy, cy, sz, cz;

  always_comb begin
    ix = ang_x_r[ANGLE_BITS-1 -: ANG_IDX_W];
    iy = ang_y_r[ANGLE_BITS-1 -: ANG_IDX_W];
    iz = ang_z_r[ANGLE_BITS-1 -: ANG_IDX_W];
    sx = cpp_sin(ix);
    cx = cpp_sin(ix + ANG_IDX_W'(32));
    sy = cpp_sin(iy);
    cy = cpp_sin(iy + ANG_IDX_W'(32));
    sz = cpp_sin(iz);
    cz = cpp_sin(iz + ANG_IDX_W'(32));
  end

  // handshake: the whole pipe advances together
  logic en;
  logic out_vld_r;
  logic [8:0] vld_r;

  assign en          = !out_vld_r || out_scr.ready;
  assign in_pt.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[7:0], in_pt.valid};
    end
  end

  // stage 1: offset from camera
  logic signed [RW-1:0] dx_r, dy_r, dz1_r;
  logic [6:0]           bef_r;

  // stage 2: first products
  logic signed [PW-1:0] p2a_r, p2b_r, p2c_r, p2d_r;
  logic signed [RW-1:0] dz2_r;
  // stage 3: rotation about z
  logic signed [RW-1:0] u3_r, v3_r, dz3_r;
  // stage 4
  logic signed [PW-1:0] p4a_r, p4b_r, p4c_r, p4d_r;
  logic signed [RW-1:0] v4_r;
  // stage 5: rotation about y
  logic signed [RW-1:0] x5_r, w5_r, v5_r;
  // stage 6
  logic signed [PW-1:0] p6a_r, p6b_r, p6c_r, p6d_r;
  logic signed [RW-1:0] x6_r;
  // stage 7: rotation about x
  logic signed [RW-1:0] x7_r, y7_r, z7_r;
  // stage 8: scale by focal length
  logic signed [NW-1:0] nx8_r, ny8_r;
  logic signed [RW-1:0] z8_r;
  logic                 vis8_r;
  // stage 9: magnitudes for the divider
  logic [NB-1:0]        mx9_r, my9_r;
  logic [DB-1:0]        md9_r;
  cpp_tag_t             tag9_r;

  logic signed [NW-1:0] nx_abs, ny_abs;
  logic signed [RW-1:0] z_abs;

  always_comb begin
    nx_abs = nx8_r[NW-1] ? -nx8_r : nx8_r;
    ny_abs = ny8_r[NW-1] ? -ny8_r : ny8_r;
    z_abs  = z8_r[RW-1]  ? -z8_r  : z8_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= RW'(in_pt.point_x) - RW'(cam_x_r);
      dy_r  <= RW'(in_pt.point_y) - RW'(cam_y_r);
      dz1_r <= RW'(in_pt.point_z) - RW'(cam_z_r);
      bef_r <= {bef_r[5:0], (in_pt.point_z < cam_z_r)};

      p2a_r <= PW'(sz) * PW'(dy_r);
      p2b_r <= PW'(cz) * PW'(dx_r);
      p2c_r <= PW'(cz) * PW'(dy_r);
      p2d_r <= PW'(sz) * PW'(dx_r);
      dz2_r <= dz1_r;

      u3_r  <= rnd((PW+1)'(p2a_r) + (PW+1)'(p2b_r));
      v3_r  <= rnd((PW+1)'(p2c_r) - (PW+1)'(p2d_r));
      dz3_r <= dz2_r;

      p4a_r <= PW'(cy) * PW'(u3_r);
      p4b_r <= PW'(sy) * PW'(dz3_r);
      p4c_r <= PW'(cy) * PW'(dz3_r);
      p4d_r <= PW'(sy) * PW'(u3_r);
      v4_r  <= v3_r;

      x5_r  <= rnd((PW+1)'(p4a_r) - (PW+1)'(p4b_r));
      w5_r  <= rnd((PW+1)'(p4c_r) + (PW+1)'(p4d_r));
      v5_r  <= v4_r;

      p6a_r <= PW'(sx) * PW'(w5_r);
      p6b_r <= PW'(cx) * PW'(v5_r);
      p6c_r <= PW'(cx) * PW'(w5_r);
      p6d_r <= PW'(sx) * PW'(v5_r);
      x6_r  <= x5_r;

      x7_r  <= x6_r;
      y7_r  <= rnd((PW+1)'(p6a_r) + (PW+1)'(p6b_r));
      z7_r  <= rnd((PW+1)'(p6c_r) - (PW+1)'(p6d_r));

      nx8_r  <= NW'(x7_r) * NW'(FOCAL_Q8);
      ny8_r  <= NW'(y7_r) * NW'(FOCAL_Q8);
      z8_r   <= z7_r;
      vis8_r <= bef_r[6] && (z7_r != '0);

      mx9_r        <= nx_abs[NB-1:0];
      my9_r        <= ny_abs[NB-1:0];
      md9_r        <= z_abs;
      tag9_r.neg_x <= nx8_r[NW-1] ^ z8_r[RW-1];
      tag9_r.neg_y <= ny8_r[NW-1] ^ z8_r[RW-1];
      tag9_r.vis   <= vis8_r;
    end
  end

  logic          dv_vld;
  logic [NB-1:0] qx, qy;
  cpp_tag_t      dv_tag;

  cpp_div #(.NB(NB), .DB(DB)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld_r[8]),
    .in_nx   (mx9_r),
    .in_ny   (my9_r),
    .in_den  (md9_r),
    .in_tag  (tag9_r),
    .out_vld (dv_vld),
    .out_qx  (qx),
    .out_qy  (qy),
    .out_tag (dv_tag)
  );

  // apply sign, then centre and saturate
  logic                 sg_vld_r;
  logic signed [NB:0]   sgx_r, sgy_r;
  logic                 sg_vis_r;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [SW-1:0] sat_x, sat_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sg_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      sg_vld_r  <= dv_vld;
      out_vld_r <= sg_vld_r;
    end
  end

  always_comb begin
    sum_x = SW'(sgx_r) + SW'(CENTRE_X_Q8);
    sum_y = SW'(sgy_r) + SW'(CENTRE_Y_Q8);
    sat_x = sum_x;
    sat_y = sum_y;
    if (sum_x > SW'(SCR_MAX)) sat_x = SW'(SCR_MAX);
    if (sum_x < SW'(SCR_MIN)) sat_x = SW'(SCR_MIN);
    if (sum_y > SW'(SCR_MAX)) sat_y = SW'(SCR_MAX);
    if (sum_y < SW'(SCR_MIN)) sat_y = SW'(SCR_MIN);
  end

  logic signed [SCR_W-1:0] scr_x_r, scr_y_r;
  logic                    vis_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sgx_r    <= dv_tag.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      sgy_r    <= dv_tag.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      sg_vis_r <= dv_tag.vis;
      scr_x_r  <= sg_vis_r ? sat_x[SCR_W-1:0] : '0;
      scr_y_r  <= sg_vis_r ? sat_y[SCR_W-1:0] : '0;
      vis_r    <= sg_vis_r;
    end
  end

  assign out_scr.valid    = out_vld_r;
  assign out_scr.screen_x = scr_x_r;
  assign out_scr.screen_y = scr_y_r;
  assign out_scr.visible  = vis_r;

endmodule

[sv/cpp_checker.sv]
`include "assert_macros.svh"

module cpp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] screen_x,
  input logic [31:0] screen_y,
  input logic        visible
);

  `CPP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid,
    "result valid straight after reset")
  `CPP_ASSERT(a_hold,
    out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y),
    "stalled result dropped or changed")
  `CPP_ASSERT(a_stall_cause, !in_ready |-> out_valid && !out_ready,
    "input held off without an output stall")
  `CPP_ASSERT(a_hidden_zero,
    out_valid && !visible |-> screen_x == '0 && screen_y == '0,
    "hidden point with nonzero screen position")

endmodule

bind camera_point_projection_unit cpp_checker u_cpp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_pt.ready),
  .out_valid (out_scr.valid),
  .out_ready (out_scr.ready),
  .screen_x  (out_scr.screen_x),
  .screen_y  (out_scr.screen_y),
  .visible   (out_scr.visible)
);

[tb/sv/camera_point_projection_unit_tb.sv]
`default_nettype none

module camera_point_projection_unit_tb
  import cpp_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 24;
  localparam int ANGLE_BITS = 16;
  localparam int CFG_W      = 24;
  localparam int DRAIN_CYC  = 80;
  localparam int HOLD_CYC   = 400;
  localparam logic [2:0] IDX_SPARE_A = 3'd6;
  localparam logic [2:0] IDX_SPARE_B = 3'd7;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               vis;
  } screen_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    bit                           typed;
    screen_t                      want;
  } point_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  cpp_pt_if #(.COORD_BITS(COORD_BITS)) pt_if ();
  cpp_scr_if scr_if ();

  camera_point_projection_unit #(
    .COORD_BITS(COORD_BITS),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pt    (pt_if.sink),
    .out_scr  (scr_if.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    pt_if.valid   = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.point_z = '0;
    scr_if.ready  = 1'b0;
  end

  // camera registers as the block should hold them
  logic signed [COORD_BITS-1:0] cam_pos [3];
  logic [ANGLE_BITS-1:0]        cam_ang [3];

  screen_t screen_q[$];
  int      err_cnt = 0;
  bit      no_idle = 0;
  bit      hold_req = 0;

  function automatic longint trig_q14(logic [6:0] idx);
    logic [4:0] f;
    longint     mag;
    f   = idx[4:0];
    mag = idx[5] ? longint'(QSINE[32 - f]) : longint'(QSINE[f]);
    return idx[6] ? -mag : mag;
  endfunction

  function automatic longint rot_mac(longint a, longint b, longint c, longint e);
    return (a * b + c * e + 8192) >>> 14;
  endfunction

  function automatic logic signed [31:0] to_screen(longint num, longint den, longint centre);
    longint q;
    q = (num * 2560) / den + centre;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic screen_t project_point(logic signed [COORD_BITS-1:0] px,
                                            logic signed [COORD_BITS-1:0] py,
                                            logic signed [COORD_BITS-1:0] pz);
    screen_t r;
    longint  dx, dy, dz, sx, cx, sy, cy, sz, cz, u, v, rx, w, ry, rz;
    logic [6:0] ix, iy, iz;
    dx = longint'(px) - longint'(cam_pos[0]);
    dy = longint'(py) - longint'(cam_pos[1]);
    dz = longint'(pz) - longint'(cam_pos[2]);
    ix = cam_ang[0][ANGLE_BITS-1 -: 7];
    iy = cam_ang[1][ANGLE_BITS-1 -: 7];
    iz = cam_ang[2][ANGLE_BITS-1 -: 7];
    sx = trig_q14(ix); cx = trig_q14(ix + 7'd32);
    sy = trig_q14(iy); cy = trig_q14(iy + 7'd32);
    sz = trig_q14(iz); cz = trig_q14(iz + 7'd32);
    u  = rot_mac(sz, dy, cz, dx);
    v  = rot_mac(cz, dy, -sz, dx);
    rx = rot_mac(cy, u, -sy, dz);
    w  = rot_mac(cy, dz, sy, u);
    ry = rot_mac(sx, w, cx, v);
    rz = rot_mac(cx, w, -sx, v);
    r = '{sx: '0, sy: '0, vis: 1'b0};
    if (dz < 0 && rz != 0) begin
      r.sx  = to_screen(rx, rz, CENTRE_X_Q8);
      r.sy  = to_screen(ry, rz, CENTRE_Y_Q8);
      r.vis = 1'b1;
    end
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx <= 3'(REG_CAMERA_Z)) cam_pos[idx] = data[COORD_BITS-1:0];
    else if (idx <= 3'(REG_ANGLE_Z)) cam_ang[idx - 3] = data[ANGLE_BITS-1:0];
  endtask

  task automatic drain();
    while (screen_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic set_camera(logic [CFG_W-1:0] x, logic [CFG_W-1:0] y, logic [CFG_W-1:0] z,
                            logic [CFG_W-1:0] ax, logic [CFG_W-1:0] ay, logic [CFG_W-1:0] az);
    drain();
    write_reg(REG_CAMERA_X, x);
    write_reg(REG_CAMERA_Y, y);
    write_reg(REG_CAMERA_Z, z);
    write_reg(REG_ANGLE_X, ax);
    write_reg(REG_ANGLE_Y, ay);
    write_reg(REG_ANGLE_Z, az);
  endtask

  // offer one beat, hold it until taken, then log what should come back
  task automatic send_point(point_row_t row);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_if.valid   <= 1'b1;
    pt_if.point_x <= row.x;
    pt_if.point_y <= row.y;
    pt_if.point_z <= row.z;
    do @(posedge clk); while (!pt_if.ready);
    screen_q.push_back(row.typed ? row.want : project_point(row.x, row.y, row.z));
  endtask

  task automatic end_burst();
    pt_if.valid <= 1'b0;
  endtask

  function automatic point_row_t mk(int x, int y, int z);
    point_row_t r;
    r.x = COORD_BITS'(x);
    r.y = COORD_BITS'(y);
    r.z = COORD_BITS'(z);
    r.typed = 0;
    r.want = '{sx: '0, sy: '0, vis: 1'b0};
    return r;
  endfunction

  function automatic point_row_t mk_typed(int x, int y, int z, int sx, int sy, bit vis);
    point_row_t r;
    r = mk(x, y, z);
    r.typed = 1;
    r.want  = '{sx: sx, sy: sy, vis: vis};
    return r;
  endfunction

  function automatic point_row_t rand_point();
    point_row_t r;
    int k;
    if ($urandom_range(0, 9) < 4) return mk($urandom, $urandom, $urandom);
    // near the camera and in front of it, offsets of every scale
    k = $urandom_range(0, 22);
    r = mk(int'(cam_pos[0]) + $signed($urandom_range(0, (2 << k) - 1)) - (1 << k),
           int'(cam_pos[1]) + $signed($urandom_range(0, (2 << k) - 1)) - (1 << k),
           int'(cam_pos[2]) - $urandom_range(1, 1 << k));
    return r;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        scr_if.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 14);
        if (n != 0) begin
          scr_if.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      scr_if.ready <= 1'b1;
      do @(posedge clk); while (!scr_if.valid);
    end
  end

  always @(posedge clk) begin
    screen_t e;
    if (rst_n && scr_if.valid && scr_if.ready) begin
      if (screen_q.size() == 0) begin
        $error("screen beat with nothing outstanding");
        err_cnt++;
      end else begin
        e = screen_q.pop_front();
        if (scr_if.screen_x !== e.sx) begin
          $error("screen_x exp %0d got %0d", e.sx, scr_if.screen_x);
          err_cnt++;
        end
        if (scr_if.screen_y !== e.sy) begin
          $error("screen_y exp %0d got %0d", e.sy, scr_if.screen_y);
          err_cnt++;
        end
        if (scr_if.visible !== e.vis) begin
          $error("visible exp %0b got %0b", e.vis, scr_if.visible);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    point_row_t directed[$];
    point_row_t quarter[$];
    int per_phase;
    cam_pos = '{0, 0, CAM_Z_RESET};
    cam_ang = '{0, 0, 0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset camera: at (0, 0, 100) looking straight down -z
    directed.push_back(mk_typed(0, 0, 0, CENTRE_X_Q8, CENTRE_Y_Q8, 1));
    directed.push_back(mk_typed(0, 0, CAM_Z_RESET, 0, 0, 0));
    directed.push_back(mk_typed(0, 0, 8388607, 0, 0, 0));
    directed.push_back(mk_typed(8388607, 0, CAM_Z_RESET - 1, 32'sh80000000, CENTRE_Y_Q8, 1));
    directed.push_back(mk_typed(-8388608, 0, CAM_Z_RESET - 1, 32'sh7fffffff, CENTRE_Y_Q8, 1));
    directed.push_back(mk(0, 8388607, CAM_Z_RESET - 1));
    directed.push_back(mk(0, -8388608, CAM_Z_RESET - 1));
    directed.push_back(mk(8388607, 8388607, -8388608));
    directed.push_back(mk(-8388608, -8388608, -8388608));
    directed.push_back(mk(256, -512, 0));
    directed.push_back(mk(-1, 1, CAM_Z_RESET - 256));
    directed.push_back(mk(12345, -6789, -100000));
    foreach (directed[i]) send_point(directed[i]);
    end_burst();

    // quarter turn about y puts dx on the depth axis; spare indexes do nothing
    set_camera(0, 0, CAM_Z_RESET, 0, 16384, 0);
    write_reg(IDX_SPARE_A, 24'h123456);
    write_reg(IDX_SPARE_B, 24'hfedcba);
    quarter.push_back(mk_typed(0, 5, 0, 0, 0, 0));
    quarter.push_back(mk(256, 5, 0));
    quarter.push_back(mk(-256, -5, 0));
    quarter.push_back(mk(8388607, 8388607, -8388608));
    foreach (quarter[i]) send_point(quarter[i]);
    end_burst();

    per_phase = 225;
    for (int ph = 0; ph < 8; ph++) begin
      unique case (ph)
        0: set_camera(0, 0, CAM_Z_RESET, 0, 0, 0);
        1: set_camera(24'h800000, 24'h800000, 24'h7fffff, 24'hffffff, 24'hffff, 24'hffff);
        2: set_camera(24'h7fffff, 24'h7fffff, 24'h800000, 0, 0, 0);
        3: set_camera(0, 0, 0, 24'hab4000, 16384, 32768);
        default: set_camera(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                            CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
      endcase
      no_idle = (ph == 4);
      if (ph == 3) hold_req = 1;
      for (int i = 0; i < per_phase; i++) send_point(rand_point());
      end_burst();
      no_idle = 0;
    end

    drain();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+sv
sv/cpp_pkg.sv
sv/cpp_if.sv
sv/cpp_div.sv
sv/camera_point_projection_unit.sv
sv/cpp_checker.sv
tb/sv/camera_point_projection_unit_tb.sv
